@@ hw/rtl/oflt_pkg.sv @@
package oflt_pkg;

   // Default sizes of the lock table
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int KEY_BITS_DEF      = 16;
   localparam int READER_BITS_DEF   = 8;

   // Fixed field widths of the channels
   localparam int FILE_ID_BITS = 16;
   localparam int MODE_BITS    = 2;
   localparam int PERM_BITS    = 9;
   localparam int ID_BITS      = 16;
   localparam int STATUS_BITS  = 3;
   localparam int DIGIT_BITS   = 3;

   // Action codes
   localparam logic ACT_OPEN  = 1'b0;
   localparam logic ACT_CLOSE = 1'b1;

   // Access mode codes; the fourth code is unused
   localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WRITE  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_APPEND = 2'd2;

   // Rights digit needed for each kind of access
   localparam logic [DIGIT_BITS-1:0] NEED_READ  = 3'd1;
   localparam logic [DIGIT_BITS-1:0] NEED_WRITE = 3'd3;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_DENIED    = 3'd1,
      ST_BUSY      = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_OPEN  = 3'd4,
      ST_NO_READER = 3'd5
   } status_type;

endpackage

@@ hw/rtl/oflt_req_if.sv @@
interface oflt_req_if;
   import oflt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [FILE_ID_BITS-1:0] file_id;
   logic [MODE_BITS-1:0]    access_mode;
   logic [PERM_BITS-1:0]    perm_bits;
   logic [ID_BITS-1:0]      owner_user;
   logic [ID_BITS-1:0]      owner_group;
   logic [ID_BITS-1:0]      requester_user;
   logic [ID_BITS-1:0]      requester_group;

   modport source (
      output valid, action, file_id, access_mode, perm_bits,
             owner_user, owner_group, requester_user, requester_group,
      input  ready
   );

   modport sink (
      input  valid, action, file_id, access_mode, perm_bits,
             owner_user, owner_group, requester_user, requester_group,
      output ready
   );

endinterface

@@ hw/rtl/oflt_rsp_if.sv @@
interface oflt_rsp_if;
   import oflt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic                   fetch_inode;
   logic                   release_inode;
   logic                   mark_dirty;

   modport source (
      output valid, status, fetch_inode, release_inode, mark_dirty,
      input  ready
   );

   modport sink (
      input  valid, status, fetch_inode, release_inode, mark_dirty,
      output ready
   );

endinterface

@@ hw/rtl/open_file_rw_lock_table.sv @@
// Open-file table with a reader/writer lock per entry.
// req_if carries one open or close request per transfer; rsp_if returns
// exactly one response per request, in request order.
// An open checks the owner, group and public rights digits, then finds or
// creates the entry for the file and takes a shared (read) or exclusive
// (write, append) lock. A close drops the lock; the last holder frees the
// entry and an append close asks for the file to be marked dirty.
// A request taken from req_if waits in the input register; its response is
// then written to the response register, which drives rsp_if.
// Throughput: one request per cycle while rsp_if is not stalled; the lookup
// is a parallel compare of all entries and the update is written in the same
// cycle, so a request always sees the table left by the one before it.
// Reset clears every entry and drops both pipeline valids.
// When the receiver stalls, the response register holds; one more request
// waits in the input register and req_if.ready falls until rsp_if moves.
module open_file_rw_lock_table #(
   parameter int TABLE_ENTRIES = oflt_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = oflt_pkg::KEY_BITS_DEF,
   parameter int READER_BITS   = oflt_pkg::READER_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   oflt_req_if.sink   req_if,
   oflt_rsp_if.source rsp_if
);
   import oflt_pkg::*;

   localparam logic [READER_BITS-1:0] READER_MAX = '1;
   localparam logic [READER_BITS-1:0] READER_ONE = READER_BITS'(1);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_action_ff;
   logic [KEY_BITS-1:0]  in_key_ff;
   logic [MODE_BITS-1:0] in_mode_ff;
   logic [PERM_BITS-1:0] in_perm_ff;
   logic                 in_user_eq_ff;
   logic                 in_group_eq_ff;

   // Table
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] writing_ff;
   logic [KEY_BITS-1:0]      key_ff     [TABLE_ENTRIES];
   logic [READER_BITS-1:0]   readers_ff [TABLE_ENTRIES];

   // Response register
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff;
   logic       out_fetch_ff, out_release_ff, out_dirty_ff;

   logic req_take, advance;

   logic [TABLE_ENTRIES-1:0] hit, free_vec, free_onehot;
   logic                     any_hit, any_free;
   logic                     hit_writing;
   logic [READER_BITS-1:0]   hit_readers;

   logic [DIGIT_BITS-1:0] own_digit, grp_digit, pub_digit;
   logic                  is_read, mode_valid, granted;
   logic                  own_ok, grp_ok, pub_ok;

   status_type status;
   logic       fetch, release_ent, dirty;
   logic       do_inc, do_dec, do_set_wr, do_clr_wr, do_alloc, do_free;

   // Handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff   <= req_if.action;
         in_key_ff      <= KEY_BITS'(req_if.file_id);
         in_mode_ff     <= req_if.access_mode;
         in_perm_ff     <= req_if.perm_bits;
         in_user_eq_ff  <= (req_if.requester_user == req_if.owner_user);
         in_group_eq_ff <= (req_if.requester_group == req_if.owner_group);
      end
   end

   // Rights check
   assign own_digit  = in_perm_ff[2:0];
   assign grp_digit  = in_perm_ff[5:3];
   assign pub_digit  = in_perm_ff[8:6];
   assign is_read    = (in_mode_ff == MODE_READ);
   assign mode_valid = (in_mode_ff == MODE_READ) || (in_mode_ff == MODE_WRITE) ||
                       (in_mode_ff == MODE_APPEND);
   assign own_ok     = own_digit >= (is_read ? NEED_READ : NEED_WRITE);
   assign grp_ok     = grp_digit >= (is_read ? NEED_READ : NEED_WRITE);
   assign pub_ok     = pub_digit >= (is_read ? NEED_READ : NEED_WRITE);
   assign granted    = mode_valid &&
                       (pub_ok || (in_group_eq_ff && grp_ok) || (in_user_eq_ff && own_ok));

   // Parallel lookup; at most one entry matches
   always_comb begin
      hit_readers = '0;
      hit_writing = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (key_ff[i] == in_key_ff);
         if (hit[i]) begin
            hit_readers = hit_readers | readers_ff[i];
            hit_writing = hit_writing | writing_ff[i];
         end
      end
   end

   assign any_hit     = |hit;
   assign free_vec    = ~valid_ff;
   assign free_onehot = free_vec & (~free_vec + TABLE_ENTRIES'(1));
   assign any_free    = |free_vec;

   always_comb begin
      status    = ST_OK;
      fetch     = 1'b0;
      release_ent = 1'b0;
      dirty     = 1'b0;
      do_inc    = 1'b0;
      do_dec    = 1'b0;
      do_set_wr = 1'b0;
      do_clr_wr = 1'b0;
      do_alloc  = 1'b0;
      do_free   = 1'b0;
      if (in_action_ff == ACT_OPEN) begin
         priority if (!granted) begin
            status = ST_DENIED;
         end else if (any_hit && is_read) begin
            if (hit_writing || hit_readers == READER_MAX) begin
               status = ST_BUSY;
            end else begin
               do_inc = 1'b1;
            end
         end else if (any_hit) begin
            if (hit_writing || hit_readers != '0) begin
               status = ST_BUSY;
            end else begin
               do_set_wr = 1'b1;
            end
         end else if (!any_free) begin
            status = ST_FULL;
         end else begin
            do_alloc = 1'b1;
            fetch    = 1'b1;
         end
      end else begin
         priority if (!any_hit) begin
            status = ST_NOT_OPEN;
         end else if (is_read) begin
            if (hit_readers == '0) begin
               status = ST_NO_READER;
            end else begin
               do_dec = 1'b1;
               // drop the entry when the last reader leaves and no writer holds it
               if (hit_readers == READER_ONE && !hit_writing) begin
                  do_free     = 1'b1;
                  release_ent = 1'b1;
               end
            end
         end else if (mode_valid) begin
            do_clr_wr = 1'b1;
            dirty     = (in_mode_ff == MODE_APPEND);
            if (hit_readers == '0) begin
               do_free     = 1'b1;
               release_ent = 1'b1;
            end
         end else begin
            status = ST_OK;
         end
      end
   end

   // Table update, applied once as the request moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         writing_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            readers_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (do_alloc && free_onehot[i]) begin
               valid_ff[i]   <= 1'b1;
               writing_ff[i] <= !is_read;
               readers_ff[i] <= is_read ? READER_ONE : '0;
            end else if (hit[i]) begin
               if (do_inc) readers_ff[i] <= readers_ff[i] + READER_ONE;
               if (do_dec) readers_ff[i] <= readers_ff[i] - READER_ONE;
               if (do_set_wr) writing_ff[i] <= 1'b1;
               if (do_clr_wr) writing_ff[i] <= 1'b0;
               if (do_free) valid_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && do_alloc) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (free_onehot[i]) key_ff[i] <= in_key_ff;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff  <= status;
         out_fetch_ff   <= fetch;
         out_release_ff <= release_ent;
         out_dirty_ff   <= dirty;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.status        = out_status_ff;
   assign rsp_if.fetch_inode   = out_fetch_ff;
   assign rsp_if.release_inode = out_release_ff;
   assign rsp_if.mark_dirty    = out_dirty_ff;

endmodule

@@ tb/open_file_rw_lock_table_tb.sv @@
`timescale 1ns / 1ps

module open_file_rw_lock_table_tb;
   import oflt_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 100;
   localparam int KEY_POOL_SIZE = 24;
   localparam int READER_LIMIT  = (1 << READER_BITS_DEF) - 1;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_AT_FIRST = 120;
   localparam int HOLD_AT_LATER = 600;
   localparam int HOLD_CYCLES   = 60;
   localparam int QUIET_FROM    = 300;
   localparam int QUIET_TO      = 450;
   localparam int TAIL_CYCLES   = 4;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam logic [PERM_BITS-1:0] PERM_ALL    = 9'o777;

   typedef struct {
      logic                    action;
      logic [FILE_ID_BITS-1:0] file_id;
      logic [MODE_BITS-1:0]    mode;
      logic [PERM_BITS-1:0]    perm;
      logic [ID_BITS-1:0]      owner_user;
      logic [ID_BITS-1:0]      owner_group;
      logic [ID_BITS-1:0]      req_user;
      logic [ID_BITS-1:0]      req_group;
      int                      gap;
      bit                      drain;
   } lock_request_type;

   typedef struct {
      status_type status;
      logic       new_entry;
      logic       frees_entry;
      logic       dirty;
   } lock_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   oflt_req_if req_bus ();
   oflt_rsp_if rsp_bus ();

   open_file_rw_lock_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // lock table shadow
   bit                      slot_valid   [TABLE_ENTRIES_DEF];
   logic [KEY_BITS_DEF-1:0] slot_key     [TABLE_ENTRIES_DEF];
   bit                      slot_writer  [TABLE_ENTRIES_DEF];
   int                      slot_readers [TABLE_ENTRIES_DEF];

   lock_request_type  pending_requests[$];
   lock_response_type expected_responses[$];
   lock_request_type  current_req;
   lock_response_type oldest_response;

   bit item_held;
   bit driver_offer;
   bit quiet_sender;
   int gap_left;
   int stall_left;
   int holdoff_left   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   logic [FILE_ID_BITS-1:0] key_pool [KEY_POOL_SIZE];

   always #CLOCK_HALF clock = ~clock;

   function automatic lock_response_type predict_lock_response(input lock_request_type r);
      lock_response_type rsp;
      int               hit;
      int               free_slot;
      logic [DIGIT_BITS-1:0] need;
      bit               mode_known;
      bit               granted;
      bit               changed;
      rsp = '{status: ST_OK, new_entry: 1'b0, frees_entry: 1'b0, dirty: 1'b0};
      hit = -1;
      free_slot = -1;
      for (int i = TABLE_ENTRIES_DEF - 1; i >= 0; i--) begin
         if (slot_valid[i] && slot_key[i] == r.file_id[KEY_BITS_DEF-1:0]) hit = i;
         if (!slot_valid[i]) free_slot = i;
      end
      if (r.action == ACT_OPEN) begin
         mode_known = (r.mode == MODE_READ || r.mode == MODE_WRITE || r.mode == MODE_APPEND);
         need = (r.mode == MODE_READ) ? NEED_READ : NEED_WRITE;
         granted = mode_known && (r.perm[8:6] >= need ||
                   (r.req_group == r.owner_group && r.perm[5:3] >= need) ||
                   (r.req_user == r.owner_user && r.perm[2:0] >= need));
         if (!granted) begin
            rsp.status = ST_DENIED;
         end else if (hit >= 0) begin
            if (r.mode == MODE_READ) begin
               if (slot_writer[hit] || slot_readers[hit] >= READER_LIMIT) rsp.status = ST_BUSY;
               else slot_readers[hit]++;
            end else begin
               if (slot_writer[hit] || slot_readers[hit] != 0) rsp.status = ST_BUSY;
               else slot_writer[hit] = 1'b1;
            end
         end else if (free_slot < 0) begin
            rsp.status = ST_FULL;
         end else begin
            slot_valid[free_slot]   = 1'b1;
            slot_key[free_slot]     = r.file_id[KEY_BITS_DEF-1:0];
            slot_writer[free_slot]  = (r.mode != MODE_READ);
            slot_readers[free_slot] = (r.mode == MODE_READ) ? 1 : 0;
            rsp.new_entry = 1'b1;
         end
      end else if (hit < 0) begin
         rsp.status = ST_NOT_OPEN;
      end else begin
         changed = 1'b1;
         case (r.mode)
            MODE_READ: begin
               if (slot_readers[hit] == 0) begin
                  rsp.status = ST_NO_READER;
                  changed = 1'b0;
               end else begin
                  slot_readers[hit]--;
               end
            end
            MODE_WRITE: slot_writer[hit] = 1'b0;
            MODE_APPEND: begin
               slot_writer[hit] = 1'b0;
               rsp.dirty = 1'b1;
            end
            default: changed = 1'b0;
         endcase
         if (changed && slot_readers[hit] == 0 && !slot_writer[hit]) begin
            slot_valid[hit] = 1'b0;
            rsp.frees_entry = 1'b1;
         end
      end
      return rsp;
   endfunction

   task automatic push_req(input logic act, input logic [FILE_ID_BITS-1:0] id,
                           input logic [MODE_BITS-1:0] mode, input logic [PERM_BITS-1:0] perm,
                           input logic [ID_BITS-1:0] ou, input logic [ID_BITS-1:0] og,
                           input logic [ID_BITS-1:0] ru, input logic [ID_BITS-1:0] rg,
                           input bit drain = 1'b0);
      lock_request_type r;
      r.action      = act;
      r.file_id     = id;
      r.mode        = mode;
      r.perm        = perm;
      r.owner_user  = ou;
      r.owner_group = og;
      r.req_user    = ru;
      r.req_group   = rg;
      r.gap         = quiet_sender ? 0 : $urandom_range(0, 5);
      r.drain       = drain;
      pending_requests.push_back(r);
   endtask

   // open or close with full public rights and random user numbers
   task automatic push_granted(input logic act, input logic [FILE_ID_BITS-1:0] id,
                               input logic [MODE_BITS-1:0] mode, input bit drain = 1'b0);
      push_req(act, id, mode, PERM_ALL, ID_BITS'($urandom), ID_BITS'($urandom),
               ID_BITS'($urandom), ID_BITS'($urandom), drain);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         item_held = 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_responses.push_back(predict_lock_response(current_req));
            accepted_count++;
            item_held = 1'b0;
         end
         if (!item_held && pending_requests.size() > 0) begin
            current_req = pending_requests.pop_front();
            gap_left = current_req.gap;
            item_held = 1'b1;
         end
         driver_offer = 1'b0;
         if (item_held) begin
            // hold an offered item until its transfer
            if (req_bus.valid && !req_bus.ready) driver_offer = 1'b1;
            else if (gap_left > 0) gap_left--;
            else if (!current_req.drain || checked_count >= accepted_count) driver_offer = 1'b1;
         end
         req_bus.valid <= driver_offer;
         if (driver_offer) begin
            req_bus.action          <= current_req.action;
            req_bus.file_id         <= current_req.file_id;
            req_bus.access_mode     <= current_req.mode;
            req_bus.perm_bits       <= current_req.perm;
            req_bus.owner_user      <= current_req.owner_user;
            req_bus.owner_group     <= current_req.owner_group;
            req_bus.requester_user  <= current_req.req_user;
            req_bus.requester_group <= current_req.req_group;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready &&
                   (checked_count == HOLD_AT_FIRST || checked_count == HOLD_AT_LATER)) begin
         holdoff_left <= HOLD_CYCLES;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response with no request outstanding: status %0d", $realtime,
                           rsp_bus.status);
            end else begin
               oldest_response = expected_responses.pop_front();
               if (rsp_bus.status !== oldest_response.status ||
                   rsp_bus.fetch_inode !== oldest_response.new_entry ||
                   rsp_bus.release_inode !== oldest_response.frees_entry ||
                   rsp_bus.mark_dirty !== oldest_response.dirty) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: response %0d expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                              $realtime, checked_count, oldest_response.status,
                              oldest_response.new_entry, oldest_response.frees_entry,
                              oldest_response.dirty, rsp_bus.status, rsp_bus.fetch_inode,
                              rsp_bus.release_inode, rsp_bus.mark_dirty);
               end
               checked_count <= checked_count + 1;
            end
            stall_left = (checked_count >= QUIET_FROM && checked_count < QUIET_TO) ?
                         0 : $urandom_range(0, 5);
         end else begin
            if (stall_left > 0) stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0 && holdoff_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [FILE_ID_BITS-1:0] fill_keys [TABLE_ENTRIES_DEF];
      logic [FILE_ID_BITS-1:0] sat_key;
      logic [FILE_ID_BITS-1:0] id;
      logic [MODE_BITS-1:0]    mode;
      logic [PERM_BITS-1:0]    perm;
      logic [ID_BITS-1:0]      ou, og, ru, rg;
      int                      pick;

      req_bus.valid           = 1'b0;
      req_bus.action          = ACT_OPEN;
      req_bus.file_id         = '0;
      req_bus.access_mode     = MODE_READ;
      req_bus.perm_bits       = '0;
      req_bus.owner_user      = '0;
      req_bus.owner_group     = '0;
      req_bus.requester_user  = '0;
      req_bus.requester_group = '0;
      rsp_bus.ready           = 1'b0;
      quiet_sender            = 1'b0;

      // directed: every status but ST_FULL, both ends of the fields
      push_req(ACT_CLOSE, 16'h0000, MODE_READ, 9'o000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_req(ACT_OPEN, 16'h0000, MODE_READ, 9'o000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_req(ACT_OPEN, 16'hFFFF, MODE_WRITE, 9'o003, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
      push_granted(ACT_OPEN, 16'hFFFF, MODE_READ);
      push_granted(ACT_OPEN, 16'hFFFF, MODE_WRITE);
      push_granted(ACT_CLOSE, 16'hFFFF, MODE_READ);
      push_granted(ACT_CLOSE, 16'hFFFF, MODE_UNUSED);
      push_granted(ACT_OPEN, 16'h0005, MODE_UNUSED);
      push_granted(ACT_CLOSE, 16'hFFFF, MODE_WRITE);
      push_req(ACT_OPEN, 16'h0001, MODE_READ, 9'o010, 16'h0011, 16'h1234, 16'h0022, 16'h1234);
      push_req(ACT_OPEN, 16'h0001, MODE_READ, 9'o100, 16'h0011, 16'h1234, 16'h0022, 16'h4321);
      push_granted(ACT_OPEN, 16'h0001, MODE_WRITE);
      push_granted(ACT_OPEN, 16'h0001, MODE_APPEND);
      push_granted(ACT_CLOSE, 16'h0001, MODE_WRITE);
      push_granted(ACT_CLOSE, 16'h0001, MODE_APPEND);
      push_granted(ACT_CLOSE, 16'h0001, MODE_READ);
      push_granted(ACT_CLOSE, 16'h0001, MODE_READ);
      push_granted(ACT_CLOSE, 16'h0001, MODE_READ);
      push_req(ACT_OPEN, 16'h0002, MODE_APPEND, 9'o300, 16'h0001, 16'h0001, 16'h0002, 16'h0002);
      push_granted(ACT_CLOSE, 16'h0002, MODE_APPEND);
      push_req(ACT_OPEN, 16'h0003, MODE_WRITE, 9'o030, 16'h0001, 16'h0001, 16'h0002, 16'h0002);
      push_req(ACT_OPEN, 16'h0003, MODE_WRITE, 9'o007, 16'h0001, 16'h0007, 16'h0002, 16'h0007);
      push_req(ACT_OPEN, 16'h0003, MODE_WRITE, 9'o002, 16'h0009, 16'h0001, 16'h0009, 16'h0002);
      push_req(ACT_OPEN, 16'h0003, MODE_READ, 9'o001, 16'h0009, 16'h0001, 16'h0009, 16'h0002);
      push_granted(ACT_CLOSE, 16'h0003, MODE_WRITE);
      push_granted(ACT_CLOSE, 16'h0003, MODE_READ);

      // fill every slot, overflow once, then empty the table again
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
         fill_keys[i] = {i[3:0], 12'($urandom)};
         push_granted(ACT_OPEN, fill_keys[i], (i % 2) ? MODE_APPEND : MODE_WRITE, i == 0);
      end
      push_granted(ACT_OPEN, fill_keys[0] ^ 16'h0001, MODE_READ);
      push_granted(ACT_OPEN, fill_keys[3], MODE_READ);
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
         push_granted(ACT_CLOSE, fill_keys[i], (i % 3 == 0) ? MODE_APPEND : MODE_WRITE);

      // saturate the reader count of one entry, back to back
      quiet_sender = 1'b1;
      sat_key = FILE_ID_BITS'($urandom);
      for (int i = 0; i <= READER_LIMIT; i++)
         push_granted(ACT_OPEN, sat_key, MODE_READ, i == 0);
      push_granted(ACT_OPEN, sat_key, MODE_WRITE);
      for (int i = 0; i <= READER_LIMIT; i++)
         push_granted(ACT_CLOSE, sat_key, MODE_READ);
      quiet_sender = 1'b0;

      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = FILE_ID_BITS'($urandom);

      // random traffic: mostly granted requests on a small set of files
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         id = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
              key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         pick = $urandom_range(0, 19);
         mode = (pick < 10) ? MODE_READ : (pick < 14) ? MODE_WRITE :
                (pick < 18) ? MODE_APPEND : MODE_UNUSED;
         perm = PERM_BITS'($urandom);
         ou = ID_BITS'($urandom);
         og = ID_BITS'($urandom);
         ru = ID_BITS'($urandom);
         rg = ID_BITS'($urandom);
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            perm[8:6] = 3'o7;
         end else if (pick < 5) begin
            rg = og;
            perm[8:6] = 3'o0;
            perm[5:3] = 3'o7;
         end else if (pick < 8) begin
            ru = ou;
            perm[8:3] = 6'o00;
            perm[2:0] = 3'o7;
         end
         push_req(($urandom_range(0, 19) < 11) ? ACT_OPEN : ACT_CLOSE, id, mode, perm,
                  ou, og, ru, rg, n == 0 || n == RANDOM_ITEMS / 2);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_requests.size() > 0 || item_held || checked_count < accepted_count)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
